FILE: rtl/rsid_pkg.sv
// shared types and constants for the ranked sorted store
`timescale 1ns / 1ps

package rsid_pkg;

    localparam int KEY_W  = 17;
    localparam int POS_W  = 10;
    localparam int RANK_W = 10;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } t_opcode;

    typedef enum logic {
        ST_INSERTED = 1'b0,
        ST_FULL     = 1'b1
    } t_status;

    typedef struct packed {
        t_opcode            opcode;
        logic [KEY_W-1:0]   key;
        logic [POS_W-1:0]   position;
    } t_req;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        t_status            status;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic ins_begin;
        logic ins_empty;
        logic ins_stop;
        logic ins_shift;
        logic ins_head;
        logic res_full;
        logic del_begin;
        logic del_shift;
    } t_dp_cmd;

    typedef struct packed {
        logic op_remove;
        logic full;
        logic empty;
        logic pos_ok;
        logic del_more_first;
        logic ins_gt;
        logic ptr_one;
        logic del_more;
    } t_dp_sts;

endpackage

FILE: rtl/rsid_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module rsid_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/rsid_dp.sv
// datapath: request latch, entry count, scan pointer, key store and result
`timescale 1ns / 1ps

module rsid_dp
    import rsid_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 17
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_req    i_req,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_rsp    o_result
);

    localparam int AW  = $clog2(CAPACITY);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [KEY_BITS-1:0] r_key;
    logic [POS_W-1:0]    r_pos;
    t_opcode             r_op;
    logic [CW-1:0]       r_count, n_count;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [AW-1:0]       r_rank, n_rank;
    t_status             r_status, n_status;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [KEY_BITS-1:0] w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [KEY_BITS-1:0] w_rdata;

    rsid_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_count  = r_count;
        n_ptr    = r_ptr;
        n_rank   = r_rank;
        n_status = r_status;
        w_we     = 1'b0;
        w_waddr  = r_ptr;
        w_wdata  = r_key;
        w_raddr  = r_ptr;
        if (i_cmd.ins_begin) begin
            w_raddr = AW'(r_count - CW'(1));
            n_ptr   = AW'(r_count);
        end
        if (i_cmd.ins_empty || i_cmd.ins_head) begin
            w_we     = 1'b1;
            w_waddr  = '0;
            n_rank   = '0;
            n_status = ST_INSERTED;
            n_count  = r_count + CW'(1);
        end
        if (i_cmd.ins_stop) begin
            w_we     = 1'b1;
            n_rank   = r_ptr;
            n_status = ST_INSERTED;
            n_count  = r_count + CW'(1);
        end
        if (i_cmd.ins_shift) begin
            w_we    = 1'b1;
            w_wdata = w_rdata;
            w_raddr = r_ptr - AW'(2);
            n_ptr   = r_ptr - AW'(1);
        end
        if (i_cmd.res_full) begin
            n_rank   = '0;
            n_status = ST_FULL;
        end
        if (i_cmd.del_begin) begin
            n_count = r_count - CW'(1);
            w_raddr = AW'(r_pos) + AW'(1);
            n_ptr   = AW'(r_pos) + AW'(1);
        end
        if (i_cmd.del_shift) begin
            w_we    = 1'b1;
            w_waddr = r_ptr - AW'(1);
            w_wdata = w_rdata;
            w_raddr = r_ptr + AW'(1);
            n_ptr   = r_ptr + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key <= KEY_BITS'(i_req.key);
            r_pos <= i_req.position;
            r_op  <= i_req.opcode;
        end
        r_ptr    <= n_ptr;
        r_rank   <= n_rank;
        r_status <= n_status;
    end

    assign o_sts.op_remove      = (r_op == OP_REMOVE);
    assign o_sts.full           = (r_count == CW'(CAPACITY));
    assign o_sts.empty          = (r_count == '0);
    assign o_sts.pos_ok         = (PW'(r_pos) < PW'(r_count));
    assign o_sts.del_more_first = ((PW'(r_pos) + PW'(1)) < PW'(r_count));
    assign o_sts.ins_gt         = (w_rdata > r_key);
    assign o_sts.ptr_one        = (r_ptr == AW'(1));
    assign o_sts.del_more       = (CW'(r_ptr) < r_count);

    assign o_result.rank   = RANK_W'(r_rank);
    assign o_result.status = r_status;

endmodule

FILE: rtl/rsid_ctrl.sv
// controller: request sequencing and output register
`timescale 1ns / 1ps

module rsid_ctrl
    import rsid_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_req_valid,
    output logic    o_req_ready,
    output logic    o_rsp_valid,
    input  logic    i_rsp_ready,
    input  t_dp_sts i_sts,
    input  t_rsp    i_result,
    output t_dp_cmd o_cmd,
    output t_rsp    o_rsp
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DECODE = 6'b000010,
        S_INS    = 6'b000100,
        S_HEAD   = 6'b001000,
        S_DEL    = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    t_rsp   r_rsp;
    logic   w_out_load;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        w_out_load  = 1'b0;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op_remove) begin
                    n_state = S_IDLE;
                    if (i_sts.pos_ok) begin
                        o_cmd.del_begin = 1'b1;
                        if (i_sts.del_more_first) begin
                            n_state = S_DEL;
                        end
                    end
                end else if (i_sts.full) begin
                    o_cmd.res_full = 1'b1;
                    n_state        = S_RESULT;
                end else if (i_sts.empty) begin
                    o_cmd.ins_empty = 1'b1;
                    n_state         = S_RESULT;
                end else begin
                    o_cmd.ins_begin = 1'b1;
                    n_state         = S_INS;
                end
            end
            S_INS: begin
                if (i_sts.ins_gt) begin
                    o_cmd.ins_stop = 1'b1;
                    n_state        = S_RESULT;
                end else begin
                    o_cmd.ins_shift = 1'b1;
                    if (i_sts.ptr_one) begin
                        n_state = S_HEAD;
                    end
                end
            end
            S_HEAD: begin
                o_cmd.ins_head = 1'b1;
                n_state        = S_RESULT;
            end
            S_DEL: begin
                o_cmd.del_shift = 1'b1;
                if (!i_sts.del_more) begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    w_out_load  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_rsp <= i_result;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

endmodule

FILE: rtl/ranked_sorted_insert_delete.sv
// top level of the ranked sorted store with insert and remove by position
`timescale 1ns / 1ps
//
// keeps up to CAPACITY keys in descending order in a single-port-pair ram
// request channel: i_req_valid / o_req_ready / i_req (opcode, key, position)
// response channel: o_rsp_valid / i_rsp_ready / o_rsp (rank, status)
// an insert gives one response, a remove gives none
// one request is worked on at a time; ready is high only while idle
// insert into a store of n keys: the ram is scanned from the tail, one key
// compared and moved up per cycle, and the response is registered once the
// slot is found (straight from decode when the store is empty or full);
// the ram read-to-compare loop sets this pace
// remove at position p: the keys above p move down, one key per cycle
// out-of-range removes change nothing
// a full store answers status 1 with rank 0 and keeps its contents
// reset empties the store at once (count to zero, no clearing pass)
// the response sits in an output register; a new request is taken while it
// waits, and a later insert holds in its result state until the slot frees

module ranked_sorted_insert_delete
    import rsid_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int KEY_BITS = 17
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_rsp    w_result;

    rsid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .i_sts       (w_sts),
        .i_result    (w_result),
        .o_cmd       (w_cmd),
        .o_rsp       (o_rsp)
    );

    rsid_dp #(
        .CAPACITY (CAPACITY),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .o_result (w_result)
    );

endmodule

FILE: rtl/rsid_checker.sv
// port checker for the ranked sorted store and its bind
`timescale 1ns / 1ps

module rsid_checker
    import rsid_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic o_req_ready,
    input logic o_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp o_rsp
);

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid && $stable(o_rsp))
        else $error("response dropped or changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while previous one in progress");

    a_no_early_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !$rose(o_rsp_valid))
        else $error("response appeared too soon after request");

    a_full_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_FULL) |-> (o_rsp.rank == '0))
        else $error("full response with nonzero rank");

endmodule

bind ranked_sorted_insert_delete rsid_checker u_checker (.*);
